// ===== src/adcpca_pkg.sv =====
// ----------------------------------------------------------------------------
// adcpca_pkg
// Shared types and constants for the ADC preemptive conversion arbiter.
// ----------------------------------------------------------------------------
package adcpca_pkg;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 16;
    localparam int SAMPLE_W = 12;
    localparam int PHASE_W  = 3;
    localparam int CHAN_W   = 2;
    localparam int SUM_W    = 32;
    localparam int SEQ_W    = 16;

    // Serial adder digit and step counts
    localparam int DIGIT_W     = 4;
    localparam int ADD_STEPS   = SUM_W / DIGIT_W;
    localparam int ADD_CNT_W   = $clog2(ADD_STEPS);
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'h0FFF;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST  = 2'd0,
        OP_INDUCT   = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_TAKE     = 2'd3
    } op_t;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FRONT = 3'd1;
    localparam logic [PHASE_W-1:0] PH_REAR  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HORIZ = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PROX  = 3'd4;

    localparam logic [CHAN_W-1:0] CH_PROX  = 2'd0;
    localparam logic [CHAN_W-1:0] CH_FRONT = 2'd1;
    localparam logic [CHAN_W-1:0] CH_REAR  = 2'd2;
    localparam logic [CHAN_W-1:0] CH_HORIZ = 2'd3;

    // Which running sum the serial adder writes back to
    typedef enum logic [1:0] {
        TGT_FRONT = 2'd0,
        TGT_REAR  = 2'd1,
        TGT_HORIZ = 2'd2,
        TGT_PROX  = 2'd3
    } tgt_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

// ===== src/adc_preemptive_conversion_arbiter.sv =====
// ----------------------------------------------------------------------------
// adc_preemptive_conversion_arbiter
// Sequences proximity and inductive conversions on one shared ADC.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives exactly one result item, which shows
// the state after the event. Requests, inductive starts, takes and ignored
// completions go from accept straight to the done state, which loads the
// output register. A completion that adds a sample first passes through the
// add state: the sample goes into its 32-bit running sum through a 4-bit
// serial adder, 8 digits at one per cycle, then the done state loads the
// output register. The completion that ends a proximity average runs the
// same serial add, then a restoring divide of the accumulator by the sample
// total, one quotient bit per cycle, then the load. A finished result sits
// in the output register and the next item is accepted while it waits; a
// computed result only stalls if the previous one is still not taken. An
// inductive start preempts proximity work and keeps its remaining sample
// count; a total of 0 gives an average of 0 and an average above 4095
// saturates.
module adc_preemptive_conversion_arbiter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [adcpca_pkg::OP_W-1:0]       operation,
    input  logic [adcpca_pkg::COUNT_W-1:0]    sample_count,
    input  logic [adcpca_pkg::SAMPLE_W-1:0]   sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [adcpca_pkg::PHASE_W-1:0]    phase,
    output logic                              start_conversion,
    output logic [adcpca_pkg::CHAN_W-1:0]     conversion_channel,
    output logic                              prox_ready,
    output logic [adcpca_pkg::SAMPLE_W-1:0]   prox_value,
    output logic [adcpca_pkg::SUM_W-1:0]      sum_front,
    output logic [adcpca_pkg::SUM_W-1:0]      sum_rear,
    output logic [adcpca_pkg::SUM_W-1:0]      sum_horizontal,
    output logic [adcpca_pkg::SEQ_W-1:0]      sequence_count
);
    import adcpca_pkg::*;

    // Arbiter state
    state_t                state_reg, state_next;
    logic [PHASE_W-1:0]    ph_reg, ph_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [SUM_W-1:0]      accum_reg, accum_next;
    logic [SAMPLE_W-1:0]   result_reg, result_next;
    logic                  rdy_reg, rdy_next;
    logic [SUM_W-1:0]      front_reg, front_next;
    logic [SUM_W-1:0]      rear_reg, rear_next;
    logic [SUM_W-1:0]      horiz_reg, horiz_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic                  start_reg, start_next;
    logic [CHAN_W-1:0]     chan_reg, chan_next;
    tgt_t                  tgt_reg, tgt_next;
    logic                  fin_reg, fin_next;

    // Serial adder
    logic [ADD_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic [SUM_W-1:0]      add_a_reg, add_a_next;
    logic [SAMPLE_W-1:0]   add_b_reg, add_b_next;
    logic                  carry_reg, carry_next;
    logic [DIGIT_W:0]      digit_sum;

    // Restoring divider
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [SUM_W-1:0]      q_reg, q_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W:0]      rem_sh;
    logic [COUNT_W:0]      rem_diff;
    logic                  rem_ge;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [PHASE_W-1:0]    out_phase_reg;
    logic                  out_start_reg;
    logic [CHAN_W-1:0]     out_chan_reg;
    logic                  out_rdy_reg;
    logic [SAMPLE_W-1:0]   out_value_reg;
    logic [SUM_W-1:0]      out_front_reg;
    logic [SUM_W-1:0]      out_rear_reg;
    logic [SUM_W-1:0]      out_horiz_reg;
    logic [SEQ_W-1:0]      out_seq_reg;

    logic [COUNT_W-1:0]    left_dec;

    assign in_ready = (state_reg == S_IDLE);

    // One 4-bit digit of the running sum per cycle, low digit first
    assign digit_sum = {1'b0, add_a_reg[DIGIT_W-1:0]} + {1'b0, add_b_reg[DIGIT_W-1:0]}
                     + {{DIGIT_W{1'b0}}, carry_reg};

    // One quotient bit per cycle
    assign rem_sh   = {rem_reg, q_reg[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, total_reg});
    assign rem_diff = rem_sh - {1'b0, total_reg};

    // Proximity countdown never wraps below zero
    assign left_dec = (left_reg != '0) ? left_reg - COUNT_W'(1) : '0;

    // Output register loads when a result is ready and the slot is free
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        left_next    = left_reg;
        total_next   = total_reg;
        accum_next   = accum_reg;
        result_next  = result_reg;
        rdy_next     = rdy_reg;
        front_next   = front_reg;
        rear_next    = rear_reg;
        horiz_next   = horiz_reg;
        seq_next     = seq_reg;
        start_next   = start_reg;
        chan_next    = chan_reg;
        tgt_next     = tgt_reg;
        fin_next     = fin_reg;
        dig_cnt_next = dig_cnt_reg;
        add_a_next   = add_a_reg;
        add_b_next   = add_b_reg;
        carry_next   = carry_reg;
        div_cnt_next = div_cnt_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next   = 1'b0;
                    chan_next    = CH_PROX;
                    fin_next     = 1'b0;
                    state_next   = S_DONE;
                    dig_cnt_next = '0;
                    carry_next   = 1'b0;
                    add_b_next   = sample;
                    unique case (op_t'(operation))
                        OP_REQUEST:
                        begin
                            // Reload counts; start only if the ADC is free
                            left_next  = sample_count;
                            total_next = sample_count;
                            accum_next = '0;
                            rdy_next   = 1'b0;
                            if (ph_reg == PH_IDLE && sample_count != '0)
                            begin
                                ph_next    = PH_PROX;
                                start_next = 1'b1;
                            end
                        end
                        OP_INDUCT:
                        begin
                            // Preempt whatever runs; keep remaining samples
                            ph_next    = PH_FRONT;
                            start_next = 1'b1;
                            chan_next  = CH_FRONT;
                        end
                        OP_COMPLETE:
                        begin
                            case (ph_reg)
                                PH_FRONT:
                                begin
                                    tgt_next   = TGT_FRONT;
                                    add_a_next = front_reg;
                                    state_next = S_ADD;
                                    ph_next    = PH_REAR;
                                    start_next = 1'b1;
                                    chan_next  = CH_REAR;
                                end
                                PH_REAR:
                                begin
                                    tgt_next   = TGT_REAR;
                                    add_a_next = rear_reg;
                                    state_next = S_ADD;
                                    ph_next    = PH_HORIZ;
                                    start_next = 1'b1;
                                    chan_next  = CH_HORIZ;
                                end
                                PH_HORIZ:
                                begin
                                    tgt_next   = TGT_HORIZ;
                                    add_a_next = horiz_reg;
                                    state_next = S_ADD;
                                    seq_next   = seq_reg + SEQ_W'(1);
                                    if (left_reg != '0)
                                    begin
                                        ph_next    = PH_PROX;
                                        start_next = 1'b1;
                                    end
                                    else
                                    begin
                                        ph_next = PH_IDLE;
                                    end
                                end
                                PH_PROX:
                                begin
                                    tgt_next   = TGT_PROX;
                                    add_a_next = accum_reg;
                                    state_next = S_ADD;
                                    left_next  = left_dec;
                                    if (left_dec != '0)
                                    begin
                                        start_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // Last sample: divide after the add
                                        fin_next = 1'b1;
                                        ph_next  = PH_IDLE;
                                    end
                                end
                                default:
                                begin
                                    // Idle or unused phase code: drop the sample
                                end
                            endcase
                        end
                        OP_TAKE:
                        begin
                            rdy_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                add_a_next   = {digit_sum[DIGIT_W-1:0], add_a_reg[SUM_W-1:DIGIT_W]};
                add_b_next   = {{DIGIT_W{1'b0}}, add_b_reg[SAMPLE_W-1:DIGIT_W]};
                carry_next   = digit_sum[DIGIT_W];
                dig_cnt_next = dig_cnt_reg + ADD_CNT_W'(1);
                if (dig_cnt_reg == ADD_CNT_W'(ADD_STEPS - 1))
                begin
                    case (tgt_reg)
                        TGT_FRONT: front_next = add_a_next;
                        TGT_REAR:  rear_next  = add_a_next;
                        TGT_HORIZ: horiz_next = add_a_next;
                        default:   accum_next = add_a_next;
                    endcase
                    if (fin_reg)
                    begin
                        q_next       = add_a_next;
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV:
            begin
                q_next       = {q_reg[SUM_W-2:0], rem_ge};
                rem_next     = rem_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    if (total_reg == '0)
                    begin
                        result_next = '0;
                    end
                    else if (q_next[SUM_W-1:SAMPLE_W] != '0)
                    begin
                        result_next = SAMPLE_MAX;
                    end
                    else
                    begin
                        result_next = q_next[SAMPLE_W-1:0];
                    end
                    rdy_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_IDLE;
            left_reg      <= '0;
            total_reg     <= '0;
            accum_reg     <= '0;
            result_reg    <= '0;
            rdy_reg       <= 1'b0;
            front_reg     <= '0;
            rear_reg      <= '0;
            horiz_reg     <= '0;
            seq_reg       <= '0;
            start_reg     <= 1'b0;
            chan_reg      <= CH_PROX;
            tgt_reg       <= TGT_FRONT;
            fin_reg       <= 1'b0;
            dig_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            left_reg      <= left_next;
            total_reg     <= total_next;
            accum_reg     <= accum_next;
            result_reg    <= result_next;
            rdy_reg       <= rdy_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            horiz_reg     <= horiz_next;
            seq_reg       <= seq_next;
            start_reg     <= start_next;
            chan_reg      <= chan_next;
            tgt_reg       <= tgt_next;
            fin_reg       <= fin_next;
            dig_cnt_reg   <= dig_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath shift registers and the output payload hold no reset
    always_ff @(posedge clk)
    begin
        add_a_reg <= add_a_next;
        add_b_reg <= add_b_next;
        carry_reg <= carry_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        if (out_load)
        begin
            out_phase_reg <= ph_reg;
            out_start_reg <= start_reg;
            out_chan_reg  <= chan_reg;
            out_rdy_reg   <= rdy_reg;
            out_value_reg <= result_reg;
            out_front_reg <= front_reg;
            out_rear_reg  <= rear_reg;
            out_horiz_reg <= horiz_reg;
            out_seq_reg   <= seq_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign phase              = out_phase_reg;
    assign start_conversion   = out_start_reg;
    assign conversion_channel = out_chan_reg;
    assign prox_ready         = out_rdy_reg;
    assign prox_value         = out_value_reg;
    assign sum_front          = out_front_reg;
    assign sum_rear           = out_rear_reg;
    assign sum_horizontal     = out_horiz_reg;
    assign sequence_count     = out_seq_reg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC preemptive conversion arbiter. Events are
// pushed through the valid/ready input one item at a time, a bench-side
// copy of the arbiter predicts the status item that each event should give,
// and every status item that leaves the block is compared field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adcpca_pkg::*;

    // No handshake on either side for this many cycles means the block hung.
    // The deliberate receiver hold-off is far shorter than this.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    // One status item as the block presents it after each event
    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic                start;
        logic [CHAN_W-1:0]   chan;
        logic                ready;
        logic [SAMPLE_W-1:0] value;
        logic [SUM_W-1:0]    front;
        logic [SUM_W-1:0]    rear;
        logic [SUM_W-1:0]    horiz;
        logic [SEQ_W-1:0]    seqs;
    } adc_status_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = OP_TAKE;
    logic [COUNT_W-1:0]  sample_count = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PHASE_W-1:0]  phase;
    logic                start_conversion;
    logic [CHAN_W-1:0]   conversion_channel;
    logic                prox_ready;
    logic [SAMPLE_W-1:0] prox_value;
    logic [SUM_W-1:0]    sum_front;
    logic [SUM_W-1:0]    sum_rear;
    logic [SUM_W-1:0]    sum_horizontal;
    logic [SEQ_W-1:0]    sequence_count;

    // Arbiter state as the bench expects it to be
    logic [PHASE_W-1:0]  arb_phase = PH_IDLE;
    logic [COUNT_W-1:0]  prox_left = '0;
    logic [COUNT_W-1:0]  prox_total = '0;
    logic [SUM_W-1:0]    prox_acc = '0;
    logic [SAMPLE_W-1:0] prox_avg = '0;
    logic                prox_flag = 1'b0;
    logic [SUM_W-1:0]    coil_front = '0;
    logic [SUM_W-1:0]    coil_rear = '0;
    logic [SUM_W-1:0]    coil_horiz = '0;
    logic [SEQ_W-1:0]    coil_seqs = '0;

    adc_status_t status_q[$];   // predicted status items, oldest first
    int          items_sent = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    bit          quiet = 1'b0;  // set: neither side idles at random

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    adc_preemptive_conversion_arbiter dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .sample_count       (sample_count),
        .sample             (sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .phase              (phase),
        .start_conversion   (start_conversion),
        .conversion_channel (conversion_channel),
        .prox_ready         (prox_ready),
        .prox_value         (prox_value),
        .sum_front          (sum_front),
        .sum_rear           (sum_rear),
        .sum_horizontal     (sum_horizontal),
        .sequence_count     (sequence_count)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Close the running average: divide by the total, clamp to 12 bits,
    // raise the ready flag and drop back to idle.
    function automatic void close_average();
        logic [SUM_W-1:0] quotient;
        quotient = (prox_total != '0) ? prox_acc / prox_total : '0;
        prox_avg = (quotient > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quotient[SAMPLE_W-1:0];
        prox_flag = 1'b1;
        arb_phase = PH_IDLE;
    endfunction

    // Apply one event to the expected state and return the status item
    // the block should show afterwards.
    function automatic adc_status_t advance_arbiter(op_t op, logic [COUNT_W-1:0] n,
                                                    logic [SAMPLE_W-1:0] smp);
        adc_status_t      s;
        logic             start;
        logic [CHAN_W-1:0] chan;
        start = 1'b0;
        chan = CH_PROX;
        case (op)
            OP_REQUEST:
            begin
                // Reload counts even while busy; only an idle block starts
                prox_left = n;
                prox_total = n;
                prox_acc = '0;
                prox_flag = 1'b0;
                if (arb_phase == PH_IDLE && n != '0)
                begin
                    arb_phase = PH_PROX;
                    start = 1'b1;
                    chan = CH_PROX;
                end
            end
            OP_INDUCT:
            begin
                // Preempt whatever runs; remaining proximity samples stay
                arb_phase = PH_FRONT;
                start = 1'b1;
                chan = CH_FRONT;
            end
            OP_COMPLETE:
            begin
                case (arb_phase)
                    PH_FRONT:
                    begin
                        coil_front = coil_front + SUM_W'(smp);
                        arb_phase = PH_REAR;
                        start = 1'b1;
                        chan = CH_REAR;
                    end
                    PH_REAR:
                    begin
                        coil_rear = coil_rear + SUM_W'(smp);
                        arb_phase = PH_HORIZ;
                        start = 1'b1;
                        chan = CH_HORIZ;
                    end
                    PH_HORIZ:
                    begin
                        coil_horiz = coil_horiz + SUM_W'(smp);
                        coil_seqs = coil_seqs + SEQ_W'(1);
                        if (prox_left != '0)
                        begin
                            arb_phase = PH_PROX;
                            start = 1'b1;
                            chan = CH_PROX;
                        end
                        else
                            arb_phase = PH_IDLE;
                    end
                    PH_PROX:
                    begin
                        prox_acc = prox_acc + SUM_W'(smp);
                        // Count down but never wrap below zero
                        if (prox_left != '0)
                            prox_left = prox_left - COUNT_W'(1);
                        if (prox_left != '0)
                        begin
                            start = 1'b1;
                            chan = CH_PROX;
                        end
                        else
                            close_average();
                    end
                    default: ;  // idle: the completion is dropped
                endcase
            end
            default: prox_flag = 1'b0;  // take
        endcase
        s.phase = arb_phase;
        s.start = start;
        s.chan  = chan;
        s.ready = prox_flag;
        s.value = prox_avg;
        s.front = coil_front;
        s.rear  = coil_rear;
        s.horiz = coil_horiz;
        s.seqs  = coil_seqs;
        return s;
    endfunction

    function automatic string show_status(adc_status_t s);
        return $sformatf("ph=%0d st=%0b ch=%0d rdy=%0b val=%0d f=%h r=%h h=%h seq=%0d",
                         s.phase, s.start, s.chan, s.ready, s.value,
                         s.front, s.rear, s.horiz, s.seqs);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, predict its status, then
    // maybe idle for a random gap.
    task automatic send_item(op_t op, logic [COUNT_W-1:0] n, logic [SAMPLE_W-1:0] smp);
        int gap;
        @(negedge clk);
        operation    = op;
        sample_count = n;
        sample       = smp;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        status_q.push_back(advance_arbiter(op, n, smp));
        items_sent++;
        gap = 0;
        if (!quiet && $urandom_range(99) < 20)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every predicted status item has come back
    task automatic wait_results_done();
        @(negedge clk);
        in_valid = 1'b0;
        while (status_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic send_noise_item();
        send_item(op_t'($urandom_range(3)), COUNT_W'($urandom_range(65535)),
                  SAMPLE_W'($urandom_range(4095)));
    endtask

    // Front, rear and horizontal conversions after a preempting start
    task automatic run_coil_sequence();
        send_item(OP_INDUCT, COUNT_W'($urandom_range(65535)), SAMPLE_W'($urandom_range(4095)));
        repeat (3)
            send_item(OP_COMPLETE, COUNT_W'($urandom_range(65535)),
                      SAMPLE_W'($urandom_range(4095)));
    endtask

    // A proximity request followed by its completions, with coil sequences
    // and stray events mixed in, usually ended by a take
    task automatic run_proximity_sequence();
        int n;
        int k;
        n = ($urandom_range(99) < 5) ? $urandom_range(16, 64) : $urandom_range(1, 6);
        send_item(OP_REQUEST, COUNT_W'(n), SAMPLE_W'($urandom_range(4095)));
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 12)
                run_coil_sequence();
            if ($urandom_range(99) < 4)
                send_noise_item();
            send_item(OP_COMPLETE, COUNT_W'($urandom_range(65535)),
                      SAMPLE_W'($urandom_range(4095)));
        end
        if ($urandom_range(99) < 70)
            send_item(OP_TAKE, COUNT_W'($urandom_range(65535)), SAMPLE_W'($urandom_range(4095)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // Completion and take with nothing running: both ignored
        send_item(OP_COMPLETE, 16'hFFFF, 12'hFFF);
        send_item(OP_TAKE, 16'h0000, 12'h000);
        // Zero-sample request loads the counters and starts nothing
        send_item(OP_REQUEST, 16'h0000, 12'hFFF);
        // Two-sample average of the largest sample and one
        send_item(OP_REQUEST, 16'd2, 12'h000);
        send_item(OP_COMPLETE, 16'h0000, 12'hFFF);
        send_item(OP_COMPLETE, 16'hFFFF, 12'h001);
        send_item(OP_TAKE, 16'h0000, 12'h000);
        // Preempt mid-average, resume, then reload to zero while busy so the
        // next completion finds no samples left and a zero total
        send_item(OP_REQUEST, 16'd3, 12'h000);
        send_item(OP_COMPLETE, 16'h0000, 12'hAAA);
        send_item(OP_INDUCT, 16'h0000, 12'h000);
        send_item(OP_COMPLETE, 16'h0000, 12'h555);
        send_item(OP_COMPLETE, 16'h0000, 12'hFFF);
        send_item(OP_COMPLETE, 16'h0000, 12'h123);
        send_item(OP_REQUEST, 16'h0000, 12'h000);
        send_item(OP_COMPLETE, 16'h0000, 12'h7FF);
        // Coil sequence from idle falls back to idle
        send_item(OP_INDUCT, 16'hFFFF, 12'hFFF);
        repeat (3) send_item(OP_COMPLETE, 16'h0000, 12'hFFF);
        // Largest request, preempted, reloaded to one during the coil
        // sequence, and preempted again while on the front coil
        send_item(OP_REQUEST, 16'hFFFF, 12'h000);
        send_item(OP_INDUCT, 16'h0000, 12'h000);
        send_item(OP_REQUEST, 16'd1, 12'h000);
        send_item(OP_INDUCT, 16'h0000, 12'h000);
        repeat (3) send_item(OP_COMPLETE, 16'h0000, 12'h800);
        send_item(OP_COMPLETE, 16'h0000, 12'hFFF);
        send_item(OP_TAKE, 16'hFFFF, 12'hFFF);
        wait_results_done();
    endtask

    task automatic test_wellformed_traffic(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 20)
                run_coil_sequence();
            else
                run_proximity_sequence();
        end
    endtask

    // Same traffic with both sides streaming back to back
    task automatic test_streaming_stretch(int target);
        quiet = 1'b1;
        test_wellformed_traffic(target);
        quiet = 1'b0;
    endtask

    // Hold off the receiver while the sender keeps offering, so the output
    // register fills and the block stalls its input; then drain fully
    task automatic test_output_backpressure();
        hold_left = HOLD_CYCLES;
        run_proximity_sequence();
        run_coil_sequence();
        run_proximity_sequence();
        wait_results_done();
    endtask

    task automatic test_random_noise(int target);
        while (items_sent < target)
            send_noise_item();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drop ready during a requested hold-off, else at random unless streaming
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (rst_n)
            out_ready = quiet || ($urandom_range(99) >= 20);
    end

    always @(posedge clk)
    begin : check_results
        adc_status_t got;
        adc_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{phase, start_conversion, conversion_channel, prox_ready, prox_value,
                    sum_front, sum_rear, sum_horizontal, sequence_count};
            if (status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item: %s", show_status(got));
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", show_status(want));
                        $display("  actual   %s", show_status(got));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, status_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_wellformed_traffic(500);
        test_streaming_stretch(700);
        test_output_backpressure();
        test_random_noise(950);
        test_wellformed_traffic(1200);

        // Let late or spurious items show up before judging
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/adcpca_pkg.sv
src/adc_preemptive_conversion_arbiter.sv
sim/tb_top.sv
